FILE: rtl/dbo_pkg.sv
package dbo_pkg;

  localparam int unsigned PRICE_W = 32;
  localparam int unsigned DISC_W  = 17;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BARRIER_KIND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BARRIER_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REBATE_AMOUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OPTION_KIND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIKE_PRICE  = 3'd4;

  // barrier kind bits
  localparam int unsigned KIND_UP_BIT  = 0;
  localparam int unsigned KIND_OUT_BIT = 1;

  localparam logic OPT_CALL = 1'b0;
  localparam logic OPT_PUT  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  localparam logic [1:0]         KIND_RESET   = 2'd0;
  localparam logic [PRICE_W-1:0] LEVEL_RESET  = 32'h0001_0000;
  localparam logic [PRICE_W-1:0] REBATE_RESET = 32'h0000_0000;
  localparam logic [PRICE_W-1:0] STRIKE_RESET = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]         barrier_kind;
    logic [PRICE_W-1:0] barrier_level;
    logic [PRICE_W-1:0] rebate_amount;
    logic               option_kind;
    logic [PRICE_W-1:0] strike_price;
  } cfg_t;

  // operands for the end-of-path scaling stage
  typedef struct packed {
    logic [PRICE_W-1:0] value;
    logic [DISC_W-1:0]  disc;
    logic               knocked;
    logic               status;
  } job_t;

endpackage

FILE: rtl/dbo_node.sv
module dbo_node (
  input  logic                         clk,
  input  logic                         rst,
  input  dbo_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dbo_pkg::PRICE_W-1:0]  spot_price,
  input  logic [dbo_pkg::DISC_W-1:0]   discount_factor,
  input  logic                         first_node,
  input  logic                         last_node,
  output logic                         job_valid,
  input  logic                         job_ready,
  output dbo_pkg::job_t                job
);

  logic                        node_valid;
  logic [dbo_pkg::PRICE_W-1:0] node_price;
  logic [dbo_pkg::DISC_W-1:0]  node_disc;
  logic                        node_first;
  logic                        node_last;

  logic                        knocked;
  logic                        knocked_next;
  logic [dbo_pkg::DISC_W-1:0]  knock_disc;
  logic [dbo_pkg::DISC_W-1:0]  knock_disc_next;

  logic                        node_done;
  logic                        node_ready;
  logic                        hit;
  logic                        up;
  logic                        is_out;
  logic [dbo_pkg::PRICE_W-1:0] vanilla;

  // a non-last node retires at once; a last node waits for the scaler
  assign node_done  = node_valid && (!node_last || job_ready);
  assign node_ready = !node_valid || node_done;
  assign in_stall   = !node_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_valid <= 1'b0;
    end else if (node_ready) begin
      node_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (node_ready && in_valid) begin
      node_price <= spot_price;
      node_disc  <= discount_factor;
      node_first <= first_node;
      node_last  <= last_node;
    end
  end

  assign up     = cfg.barrier_kind[dbo_pkg::KIND_UP_BIT];
  assign is_out = cfg.barrier_kind[dbo_pkg::KIND_OUT_BIT];
  assign hit    = up ? (node_price >= cfg.barrier_level) : (node_price <= cfg.barrier_level);

  always_comb begin
    knocked_next    = knocked;
    knock_disc_next = knock_disc;
    if (node_first) begin
      knocked_next    = 1'b0;
      knock_disc_next = '0;
    end else if (hit) begin
      knocked_next = 1'b1;
      if (!knocked) begin
        knock_disc_next = node_disc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      knocked    <= 1'b0;
      knock_disc <= '0;
    end else if (node_done) begin
      knocked    <= knocked_next;
      knock_disc <= knock_disc_next;
    end
  end

  always_comb begin
    if (cfg.option_kind == dbo_pkg::OPT_PUT) begin
      vanilla = (cfg.strike_price > node_price) ? cfg.strike_price - node_price : '0;
    end else begin
      vanilla = (node_price > cfg.strike_price) ? node_price - cfg.strike_price : '0;
    end
  end

  always_comb begin
    job.knocked = knocked_next;
    job.status  = dbo_pkg::STATUS_OK;
    job.disc    = node_disc;
    if (node_first) begin
      // single-node path: zero value, short status
      job.value   = '0;
      job.disc    = '0;
      job.knocked = 1'b0;
      job.status  = dbo_pkg::STATUS_SHORT;
    end else if (is_out) begin
      if (knocked_next) begin
        job.value = cfg.rebate_amount;
        job.disc  = knock_disc_next;
      end else begin
        job.value = vanilla;
      end
    end else begin
      job.value = knocked_next ? vanilla : cfg.rebate_amount;
    end
  end

  assign job_valid = node_valid && node_last;

endmodule

FILE: rtl/dbo_scale.sv
module dbo_scale (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  dbo_pkg::job_t                job,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dbo_pkg::PRICE_W-1:0]  path_value,
  output logic                         was_knocked,
  output logic                         status
);

  localparam int unsigned PROD_W = dbo_pkg::PRICE_W + dbo_pkg::DISC_W;
  localparam int unsigned SHR_W  = PROD_W - dbo_pkg::FRAC_W;

  logic                 op_valid;
  dbo_pkg::job_t        op;
  logic                 op_ready;
  logic                 res_ready;
  logic [PROD_W-1:0]    prod;
  logic [SHR_W-1:0]     scaled;
  logic [dbo_pkg::PRICE_W-1:0] sat;

  assign res_ready = !out_valid || !out_stall;
  assign op_ready  = !op_valid || res_ready;
  assign job_ready = op_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (op_ready) begin
      op_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_ready && job_valid) begin
      op <= job;
    end
  end

  // Q16.16 x Q1.16, floor to Q16.16, clamp at all-ones
  assign prod   = PROD_W'(op.value) * PROD_W'(op.disc);
  assign scaled = prod[PROD_W-1:dbo_pkg::FRAC_W];
  assign sat    = (|scaled[SHR_W-1:dbo_pkg::PRICE_W]) ? '1 : scaled[dbo_pkg::PRICE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && op_valid) begin
      path_value  <= sat;
      was_knocked <= op.knocked;
      status      <= op.status;
    end
  end

endmodule

FILE: rtl/discrete_barrier_option_payoff.sv
// A last path node's result passes the node register, the operand register and
// the result register on its way out.
// Throughput: one path node per cycle; only output back-pressure stalls input.
// Reset (synchronous, active high) empties the pipeline, clears the knock state
// and loads register defaults: down-in call, barrier 1.0, rebate 0, strike 1.0.
module discrete_barrier_option_payoff (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dbo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dbo_pkg::PRICE_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dbo_pkg::PRICE_W-1:0]    spot_price,
  input  logic [dbo_pkg::DISC_W-1:0]     discount_factor,
  input  logic                           first_node,
  input  logic                           last_node,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dbo_pkg::PRICE_W-1:0]    path_value,
  output logic                           was_knocked,
  output logic                           status
);

  dbo_pkg::cfg_t cfg;
  logic          job_valid;
  logic          job_ready;
  dbo_pkg::job_t job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.barrier_kind  <= dbo_pkg::KIND_RESET;
      cfg.barrier_level <= dbo_pkg::LEVEL_RESET;
      cfg.rebate_amount <= dbo_pkg::REBATE_RESET;
      cfg.option_kind   <= dbo_pkg::OPT_CALL;
      cfg.strike_price  <= dbo_pkg::STRIKE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dbo_pkg::CFG_BARRIER_KIND:  cfg.barrier_kind  <= cfg_data[1:0];
        dbo_pkg::CFG_BARRIER_LEVEL: cfg.barrier_level <= cfg_data;
        dbo_pkg::CFG_REBATE_AMOUNT: cfg.rebate_amount <= cfg_data;
        dbo_pkg::CFG_OPTION_KIND:   cfg.option_kind   <= cfg_data[0];
        dbo_pkg::CFG_STRIKE_PRICE:  cfg.strike_price  <= cfg_data;
        default: ;
      endcase
    end
  end

  dbo_node u_node (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .spot_price      (spot_price),
    .discount_factor (discount_factor),
    .first_node      (first_node),
    .last_node       (last_node),
    .job_valid       (job_valid),
    .job_ready       (job_ready),
    .job             (job)
  );

  dbo_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .path_value  (path_value),
    .was_knocked (was_knocked),
    .status      (status)
  );

`ifndef SYNTHESIS
  // input back-pressure only ever comes from a held result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result beat");

  // a short path carries neither value nor knock
  a_short_path: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == dbo_pkg::STATUS_SHORT) |-> (path_value == '0 && !was_knocked))
    else $error("short-path result with value or knock set");

  // a job taken by the scaler is never flagged both short and knocked
  a_job_only_last: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> !job_ready || $countones({job.status, job.knocked}) <= 1)
    else $error("scaler job flagged both short and knocked");
`endif

endmodule

FILE: verif/dbo_path_checker.sv
module dbo_path_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [dbo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dbo_pkg::PRICE_W-1:0]   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [dbo_pkg::PRICE_W-1:0]   spot_price,
  input  logic [dbo_pkg::DISC_W-1:0]    discount_factor,
  input  logic                          first_node,
  input  logic                          last_node,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [dbo_pkg::PRICE_W-1:0]   path_value,
  input  logic                          was_knocked,
  input  logic                          status,
  output int                            n_errors,
  output int                            n_pending,
  output int                            n_results,
  output int                            n_knocked,
  output int                            n_short
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PW     = dbo_pkg::PRICE_W;
  localparam int unsigned DW     = dbo_pkg::DISC_W;
  localparam int unsigned FW     = dbo_pkg::FRAC_W;
  localparam int unsigned PROD_W = PW + DW;

  typedef struct packed {
    logic [PW-1:0] value;
    logic          knocked;
    logic          status;
  } path_result_t;

  dbo_pkg::cfg_t      opt_cfg;
  logic               path_knocked;
  logic [DW-1:0]      path_knock_disc;
  path_result_t       owed_q[$];

  // Q16.16 times Q1.16, floor back to Q16.16, clamp at the top
  function automatic logic [PW-1:0] discount_value(logic [PW-1:0] v, logic [DW-1:0] d);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(v) * PROD_W'(d);
    return prod[PROD_W-1] ? '1 : prod[PW+FW-1:FW];
  endfunction

  function automatic logic [PW-1:0] intrinsic_value(logic [PW-1:0] s);
    if (opt_cfg.option_kind == dbo_pkg::OPT_CALL)
      return (s > opt_cfg.strike_price) ? s - opt_cfg.strike_price : '0;
    return (opt_cfg.strike_price > s) ? opt_cfg.strike_price - s : '0;
  endfunction

  task automatic price_node(logic [PW-1:0] s, logic [DW-1:0] d,
                            logic first, logic last);
    path_result_t r;
    logic         up;
    logic         is_out;
    up     = opt_cfg.barrier_kind[dbo_pkg::KIND_UP_BIT];
    is_out = opt_cfg.barrier_kind[dbo_pkg::KIND_OUT_BIT];
    if (first) begin
      path_knocked    = 1'b0;
      path_knock_disc = '0;
      if (last) begin
        r = '{value: '0, knocked: 1'b0, status: dbo_pkg::STATUS_SHORT};
        owed_q.push_back(r);
      end
      return;
    end
    if (up ? (s >= opt_cfg.barrier_level) : (s <= opt_cfg.barrier_level)) begin
      if (!path_knocked)
        path_knock_disc = d;
      path_knocked = 1'b1;
    end
    if (!last)
      return;
    if (is_out)
      r.value = path_knocked ? discount_value(opt_cfg.rebate_amount, path_knock_disc)
                             : discount_value(intrinsic_value(s), d);
    else
      r.value = path_knocked ? discount_value(intrinsic_value(s), d)
                             : discount_value(opt_cfg.rebate_amount, d);
    r.knocked = path_knocked;
    r.status  = dbo_pkg::STATUS_OK;
    owed_q.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    path_result_t want;
    if (rst) begin
      opt_cfg.barrier_kind  = dbo_pkg::KIND_RESET;
      opt_cfg.barrier_level = dbo_pkg::LEVEL_RESET;
      opt_cfg.rebate_amount = dbo_pkg::REBATE_RESET;
      opt_cfg.option_kind   = dbo_pkg::OPT_CALL;
      opt_cfg.strike_price  = dbo_pkg::STRIKE_RESET;
      path_knocked          = 1'b0;
      path_knock_disc       = '0;
      owed_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dbo_pkg::CFG_BARRIER_KIND:  opt_cfg.barrier_kind  = cfg_data[1:0];
          dbo_pkg::CFG_BARRIER_LEVEL: opt_cfg.barrier_level = cfg_data;
          dbo_pkg::CFG_REBATE_AMOUNT: opt_cfg.rebate_amount = cfg_data;
          dbo_pkg::CFG_OPTION_KIND:   opt_cfg.option_kind   = cfg_data[0];
          dbo_pkg::CFG_STRIKE_PRICE:  opt_cfg.strike_price  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result beat value=%h knocked=%b status=%b",
                   $time, path_value, was_knocked, status);
          n_errors++;
        end else begin
          want = owed_q.pop_front();
          n_results++;
          if (want.knocked) n_knocked++;
          if (want.status == dbo_pkg::STATUS_SHORT) n_short++;
          if (path_value !== want.value) begin
            $display("%0t: path_value expected %h got %h", $time, want.value, path_value);
            n_errors++;
          end
          if (was_knocked !== want.knocked) begin
            $display("%0t: was_knocked expected %b got %b", $time, want.knocked,
                     was_knocked);
            n_errors++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %b got %b", $time, want.status, status);
            n_errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        price_node(spot_price, discount_factor, first_node, last_node);
    end
    n_pending = owed_q.size();
  end

  initial begin
    n_errors  = 0;
    n_pending = 0;
    n_results = 0;
    n_knocked = 0;
    n_short   = 0;
  end

endmodule

FILE: verif/discrete_barrier_option_payoff_tb.sv
module discrete_barrier_option_payoff_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_NODES = 1930;
  localparam int N_PHASES     = 12;

  localparam int unsigned PW = dbo_pkg::PRICE_W;
  localparam int unsigned DW = dbo_pkg::DISC_W;
  localparam int unsigned IW = dbo_pkg::CFG_IDX_W;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IW-1:0]        cfg_index = '0;
  logic [PW-1:0]        cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PW-1:0]        spot_price = '0;
  logic [DW-1:0]        discount_factor = '0;
  logic                 first_node = 1'b0;
  logic                 last_node = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PW-1:0]        path_value;
  logic                 was_knocked;
  logic                 status;

  int n_errors, n_pending, n_results, n_knocked, n_short;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int nodes_sent   = 0;
  int quiet_cycles = 0;

  logic [PW-1:0] cur_level  = dbo_pkg::LEVEL_RESET;
  logic [PW-1:0] cur_strike = dbo_pkg::STRIKE_RESET;

  discrete_barrier_option_payoff u_top (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .spot_price, .discount_factor, .first_node, .last_node,
    .out_valid, .out_stall, .path_value, .was_knocked, .status
  );

  dbo_path_checker u_checker (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .spot_price, .discount_factor, .first_node, .last_node,
    .out_valid, .out_stall, .path_value, .was_knocked, .status,
    .n_errors, .n_pending, .n_results, .n_knocked, .n_short
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < snk_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
        (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles at %0t", quiet_cycles, $time);
        $display("discrete_barrier_option_payoff_tb: errors");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [IW-1:0] idx, logic [PW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_option(logic [1:0] kind, logic [PW-1:0] level,
                            logic [PW-1:0] rebate, logic opt,
                            logic [PW-1:0] strike);
    write_reg(dbo_pkg::CFG_BARRIER_KIND, PW'(kind));
    write_reg(dbo_pkg::CFG_BARRIER_LEVEL, level);
    write_reg(dbo_pkg::CFG_REBATE_AMOUNT, rebate);
    write_reg(dbo_pkg::CFG_OPTION_KIND, PW'(opt));
    write_reg(dbo_pkg::CFG_STRIKE_PRICE, strike);
    cur_level  = level;
    cur_strike = strike;
  endtask

  task automatic send_node(logic [PW-1:0] s, logic [DW-1:0] d,
                           logic first, logic last);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    spot_price      <= s;
    discount_factor <= d;
    first_node      <= first;
    last_node       <= last;
    do @(posedge clk); while (in_stall);
    nodes_sent++;
  endtask

  // drop valid, let every owed result out, then give the pipe time to empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (n_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [PW-1:0] pick_price();
    logic [PW-1:0] off;
    off = PW'($urandom_range(32'h40000));
    case ($urandom_range(11))
      0, 1, 2, 3: return cur_level + off - 32'h20000;
      4:          return cur_level;
      5:          return cur_level + PW'($urandom_range(2)) - 1;
      6, 7:       return cur_strike + off - 32'h20000;
      8, 9:       return $urandom;
      10:         return '0;
      default:    return '1;
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_disc();
    case ($urandom_range(9))
      7:       return DW'(32'h10000);
      8:       return DW'($urandom_range(32'h1FFFF));
      9:       return '0;
      default: return DW'($urandom_range(32'h10000));
    endcase
  endfunction

  // mostly well-formed paths; some lose their opening or closing mark
  task automatic run_paths(int n_nodes);
    int  len;
    int  stop;
    logic drop_first, drop_last;
    stop = nodes_sent + n_nodes;
    while (nodes_sent < stop) begin
      len        = ($urandom_range(99) < 8) ? 1 : $urandom_range(2, 7);
      drop_first = ($urandom_range(99) < 8);
      drop_last  = ($urandom_range(99) < 8);
      for (int i = 0; i < len; i++)
        send_node(pick_price(), pick_disc(), (i == 0) && !drop_first,
                  (i == len - 1) && !drop_last);
    end
  endtask

  initial begin
    logic [PW-1:0] level, rebate, strike;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    src_idle_pct = 29;
    snk_idle_pct = 54;

    // reset settings: down-in call, barrier and strike at 1.0, no rebate
    send_node(32'h0, 17'h10000, 1'b0, 1'b0);        // node ahead of any path start
    send_node(32'hFFFF_FFFF, 17'h1FFFF, 1'b0, 1'b1); // discount above 1.0, clamps
    send_node(32'h1234_5678, 17'h0FFFF, 1'b1, 1'b1); // single-node path
    send_node(32'h0, 17'h10000, 1'b1, 1'b0);         // opening node is not checked
    send_node(32'h0002_0000, 17'h0F000, 1'b0, 1'b0);
    send_node(32'h0003_0000, 17'h08000, 1'b0, 1'b1);
    settle();

    set_option(2'd3, 32'h0002_0000, 32'hFFFF_FFFF, dbo_pkg::OPT_PUT, 32'hFFFF_FFFF);
    send_node(32'hFFFF_FFFF, 17'h10000, 1'b1, 1'b0);
    send_node(32'h0001_FFFF, 17'h0E000, 1'b0, 1'b0);
    send_node(32'h0002_0000, 17'h0C000, 1'b0, 1'b0); // first touch sets the discount
    send_node(32'hFFFF_FFFF, 17'h08000, 1'b0, 1'b0);
    send_node(32'h0, 17'h0, 1'b0, 1'b1);
    send_node(32'h0, 17'h10000, 1'b1, 1'b0);
    send_node(32'h0001_0000, 17'h10000, 1'b0, 1'b1);
    settle();

    // zero barrier: down side touches only at a zero price
    set_option(2'd2, 32'h0, 32'h1234_5678, dbo_pkg::OPT_CALL, 32'h0);
    send_node(32'h0, 17'h10000, 1'b1, 1'b0);
    send_node(32'h1, 17'h1FFFF, 1'b0, 1'b0);
    send_node(32'h0, 17'h10000, 1'b0, 1'b1);
    settle();

    // zero barrier, up side: every checked node touches
    set_option(2'd1, 32'h0, 32'h0001_0000, dbo_pkg::OPT_CALL, 32'h0);
    send_node(32'h5, 17'h10000, 1'b1, 1'b0);
    send_node(32'hFFFF_FFFF, 17'h10000, 1'b0, 1'b1);
    send_node(32'h0, 17'h0, 1'b1, 1'b0);
    send_node(32'h0, 17'h10000, 1'b1, 1'b0);          // path restarted without an end
    send_node(32'h7, 17'h1FFFF, 1'b0, 1'b1);
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p / 4)
        0: begin src_idle_pct = 29; snk_idle_pct = 54; end
        1: begin src_idle_pct = 54; snk_idle_pct = 29; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      case (p % 6)
        0: level = 32'h0001_0000 + PW'($urandom_range(32'hFFFF));
        1: level = 32'h1;
        2: level = 32'hFFFF_FFFF;
        3: level = $urandom;
        4: level = PW'($urandom_range(32'h0040_0000, 32'h0001_0000));
        default: level = $urandom | 32'h1;
      endcase
      case (p % 3)
        0: rebate = '0;
        1: rebate = '1;
        default: rebate = $urandom;
      endcase
      case ((p / 3) % 4)
        0: strike = '0;
        1: strike = '1;
        2: strike = level;
        default: strike = $urandom;
      endcase
      set_option(2'(p % 4), level, rebate, logic'(p[2] ^ p[1]), strike);
      run_paths(RANDOM_NODES / N_PHASES);
      settle();
    end

    $display("covered %0d path nodes, %0d results (%0d knocked, %0d single-node)",
             nodes_sent, n_results, n_knocked, n_short);
    $display("all four barrier kinds with calls and puts, %0d option settings", N_PHASES + 4);
    if (n_errors == 0) begin
      $display("discrete_barrier_option_payoff_tb: clean");
    end else begin
      $display("discrete_barrier_option_payoff_tb: errors");
    end
    $finish;
  end

endmodule
